// ===== src/lrc_pkg.sv =====
// Package for the LRU tagged cache policy core.
// Holds the request and response beat types and the request codes.
// No dependencies.
package lrc_pkg;

  // Width of the global recency stamp; it wraps naturally at this width.
  localparam int STAMP_W = 31;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_value;
    logic [3:0]  slot;
    logic        evicted;
  } rsp_t;

endpackage

// ===== src/lrc_mem.sv =====
// Entry storage for the LRU tagged cache policy core.
// One write port and one read port with a registered read.
// No package dependencies.
module lrc_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 127
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lrc_ctrl.sv =====
// Scan sequencer for the LRU tagged cache policy core.
// Walks the entry memory once per request, tracks the match, free or oldest entry,
// then writes back the hit or inserted entry and hands the response to the output stage.
// Depends on lrc_pkg.
module lrc_ctrl #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4,
  parameter int ENT_W      = 127
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lrc_pkg::req_t      req_data,
  input  logic               rsp_free,
  output logic               rsp_load,
  output lrc_pkg::rsp_t      rsp_beat,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ENT_W-1:0]   rd_data,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [ENT_W-1:0]   wr_data
);
  import lrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t               state;
  logic [IDX_W-1:0]     scan_addr;
  logic                 chk_en;
  logic [IDX_W-1:0]     chk_idx;
  logic                 chk_valid;
  logic                 op;
  logic [KEY_BITS-1:0]  key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic [VALUE_BITS-1:0] hit_data;
  logic                 old_set;
  logic [IDX_W-1:0]     old_idx;
  logic [STAMP_W-1:0]   old_stamp;
  logic [STAMP_W-1:0]   stamp_counter;
  logic [ENTRIES-1:0]   valid_bits;

  logic [KEY_BITS-1:0]   ent_tag;
  logic [VALUE_BITS-1:0] ent_data;
  logic [STAMP_W-1:0]    ent_stamp;
  logic [63:0]           key_wide;
  logic [63:0]           value_wide;
  logic [63:0]           hit_wide;
  logic [7:0]            slot_wide;
  logic                  is_hit;

  // Split the entry read from memory into its fields.
  assign ent_stamp = rd_data[STAMP_W-1:0];
  assign ent_data  = rd_data[STAMP_W +: VALUE_BITS];
  assign ent_tag   = rd_data[STAMP_W+VALUE_BITS +: KEY_BITS];

  // Keep only the configured key and value bits of the request.
  assign key_wide   = req_data.key;
  assign value_wide = 64'(req_data.value);

  // Memory read side follows the scan address.
  assign req_ready = (state == S_IDLE);
  assign rd_en     = (state == S_SCAN);
  assign rd_addr   = scan_addr;

  // Write-back: a hit refreshes its stamp, an insert fills the free or oldest entry.
  assign is_hit   = (op == REQ_LOOKUP) && found;
  assign rsp_load = (state == S_WRITE) && rsp_free;
  assign wr_en    = rsp_load && ((op == REQ_INSERT) || found);
  assign wr_addr  = found ? found_idx : old_idx;
  assign wr_data  = {key_q, (op == REQ_INSERT) ? value_q : hit_data, stamp_counter};

  // Response beat.
  assign hit_wide  = 64'(hit_data);
  assign slot_wide = 8'(wr_addr);
  always_comb begin
    rsp_beat.hit       = is_hit;
    rsp_beat.hit_value = is_hit ? hit_wide[31:0] : 32'd0;
    rsp_beat.slot      = ((op == REQ_INSERT) || found) ? slot_wide[3:0] : 4'd0;
    rsp_beat.evicted   = (op == REQ_INSERT) && !found;
  end

  // Sequencer, scan pipeline and per-entry evaluation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      chk_en        <= 1'b0;
      found         <= 1'b0;
      old_set       <= 1'b0;
      valid_bits    <= '0;
      stamp_counter <= '0;
    end else begin
      chk_en    <= (state == S_SCAN);
      chk_idx   <= scan_addr;
      chk_valid <= valid_bits[scan_addr];

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op        <= req_data.req_type;
            key_q     <= key_wide[KEY_BITS-1:0];
            value_q   <= value_wide[VALUE_BITS-1:0];
            scan_addr <= '0;
            found     <= 1'b0;
            old_set   <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (rsp_free) begin
            if (wr_en) begin
              valid_bits[wr_addr] <= 1'b1;
              stamp_counter       <= stamp_counter + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // The first matching, or first free, entry wins; later entries are ignored.
      if (chk_en && !found) begin
        if (op == REQ_LOOKUP) begin
          if (chk_valid && (ent_tag == key_q)) begin
            found     <= 1'b1;
            found_idx <= chk_idx;
            hit_data  <= ent_data;
          end
        end else if (!chk_valid) begin
          found     <= 1'b1;
          found_idx <= chk_idx;
        end else if (!old_set || (ent_stamp < old_stamp)) begin
          old_set   <= 1'b1;
          old_idx   <= chk_idx;
          old_stamp <= ent_stamp;
        end
      end
    end
  end

endmodule

// ===== src/lru_tagged_cache_policy_core.sv =====
// Top level of the LRU tagged cache policy core.
// Instantiates lrc_ctrl and lrc_mem and holds the response register.
// Depends on lrc_pkg.
//
// Usage:
//   The req channel (req_valid, req_ready, req_data) takes one lookup or insert
//   beat at a time. The rsp channel (rsp_valid, rsp_ready, rsp_data) returns
//   exactly one beat per request, in order.
//   Each request reads every entry once through the entry memory,
//   one entry per cycle, and goes from accept to the next accept through
//   the accept state, the entry reads, a drain state for the last read
//   data and a write-back state. The response is registered and is
//   visible in the cycle after write-back.
//   The response register lets the next request start while a response still
//   waits; if the receiver stalls longer, the core holds in write-back until
//   the register frees, and no beat is lost.
//   Reset clears all valid bits and the stamp counter at once; the core
//   accepts a request in the first cycle after reset.
module lru_tagged_cache_policy_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lrc_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lrc_pkg::rsp_t rsp_data
);
  import lrc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = KEY_BITS + VALUE_BITS + STAMP_W;

  logic             rsp_free;
  logic             rsp_load;
  rsp_t             rsp_beat;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  assign rsp_free = !rsp_valid || rsp_ready;

  lrc_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .ENT_W      (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_free  (rsp_free),
    .rsp_load  (rsp_load),
    .rsp_beat  (rsp_beat),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  lrc_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W),
    .DW    (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
      rsp_data  <= rsp_beat;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
